/* sv/rs14_pkg.sv */
package rs14_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CandW   = 14;
  localparam int unsigned IdxW    = 8;
  localparam int unsigned ModW    = 15;
  localparam int unsigned TgtW    = 9;

  // group geometry: seven bytes cut into four candidates
  localparam int unsigned GroupLen = 7;
  localparam int unsigned NumCand  = 4;
  localparam int unsigned PosW     = 3;
  localparam int unsigned HeldW    = ByteW * (GroupLen - 1);
  localparam int unsigned WordW    = ByteW * GroupLen;

  // coefficient count
  localparam int unsigned MaxCoeffs = 256;
  localparam int unsigned CntW      = 9;

  // reset values of the registers
  localparam logic [ModW-1:0] ModulusReset = 15'd12289;
  localparam logic [TgtW-1:0] TargetReset  = 9'd256;

  localparam logic [PosW-1:0] LastPos = PosW'(GroupLen - 1);
  localparam logic [CntW-1:0] MaxCnt  = CntW'(MaxCoeffs);

  // register map: register index taken from paddr[2]
  typedef enum logic {
    RegModulus = 1'b0,
    RegTarget  = 1'b1
  } cfg_reg_e;

  typedef logic [CandW-1:0] cand_t;
  typedef logic [IdxW-1:0]  idx_t;

  // the candidates of one group with their accept flags
  typedef struct packed {
    logic [NumCand-1:0]  take;
    cand_t [NumCand-1:0] coef;
    idx_t  [NumCand-1:0] idx;
    logic [NumCand-1:0]  last;
  } bundle_t;

endpackage

/* sv/rs14_if.sv */
// byte stream channel
interface rs14_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rand_byte;
  logic       buffer_end;
  logic       new_poly;

  modport source(output valid, rand_byte, buffer_end, new_poly, input ready);
  modport sink(input valid, rand_byte, buffer_end, new_poly, output ready);
endinterface

// coefficient channel
interface rs14_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] coefficient;
  logic [7:0]  coeff_index;
  logic        last_coeff;

  modport source(output valid, coefficient, coeff_index, last_coeff, input ready);
  modport sink(input valid, coefficient, coeff_index, last_coeff, output ready);
endinterface

/* sv/rejection_sampler_14bit.sv */
// the first coefficient of a group passes the result buffer, then the output register,
// after its seventh byte is taken; throughput: one byte per cycle but for closing-byte
// waits; one coefficient word per cycle leaves the result buffer while the output is free
// or ready; a closing byte waits only while the four-slot result buffer still holds words
// reset: asynchronous, active low; clears group, count and buffers, modulus 12289, target 256
module rejection_sampler_14bit (
  input  logic        clk_i,
  input  logic        rst_ni,
  rs14_in_if.sink     in_i,
  rs14_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [rs14_pkg::ModW-1:0] modulus;
  logic [rs14_pkg::TgtW-1:0] target;
  logic                      busy, load;
  rs14_pkg::bundle_t         bundle;

  // configuration registers
  rs14_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .modulus_o (modulus),
    .target_o  (target)
  );

  // group assembly and candidate tests
  rs14_sampler u_sampler (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .modulus_i (modulus),
    .target_i  (target),
    .busy_i    (busy),
    .load_o    (load),
    .bundle_o  (bundle)
  );

  // result buffer and output register
  rs14_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .bundle_i (bundle),
    .busy_o   (busy),
    .out_o    (out_o)
  );

  // a group never overwrites words still pending
  assert property (@(posedge clk_i) disable iff (!rst_ni) load |-> !busy)
    else $error("group loaded over pending words");

  // the byte side stalls only while the result buffer holds pending words
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_i.ready |-> busy)
    else $error("byte stall without pending words");

  // pending words reach the output register while it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !out_o.valid) |=> out_o.valid)
    else $error("pending word not moved to output");

endmodule

/* sv/rs14_cfg.sv */
module rs14_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [rs14_pkg::ModW-1:0] modulus_o,
  output logic [rs14_pkg::TgtW-1:0] target_o
);

  logic [rs14_pkg::ModW-1:0] modulus_q;
  logic [rs14_pkg::TgtW-1:0] target_q;
  rs14_pkg::cfg_reg_e        sel;
  logic                      wr_en;

  assign pready = 1'b1;
  assign sel    = rs14_pkg::cfg_reg_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= rs14_pkg::ModulusReset;
      target_q  <= rs14_pkg::TargetReset;
    end else if (wr_en) begin
      unique case (sel)
        rs14_pkg::RegModulus: modulus_q <= pwdata[rs14_pkg::ModW-1:0];
        rs14_pkg::RegTarget:  target_q  <= pwdata[rs14_pkg::TgtW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (sel)
      rs14_pkg::RegModulus: prdata = 32'(modulus_q);
      rs14_pkg::RegTarget:  prdata = 32'(target_q);
      default:              prdata = '0;
    endcase
  end

  assign modulus_o = modulus_q;
  assign target_o  = target_q;

endmodule

/* sv/rs14_sampler.sv */
module rs14_sampler (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rs14_in_if.sink                   in_i,
  input  logic [rs14_pkg::ModW-1:0] modulus_i,
  input  logic [rs14_pkg::TgtW-1:0] target_i,
  input  logic                      busy_i,
  output logic                      load_o,
  output rs14_pkg::bundle_t         bundle_o
);

  logic [rs14_pkg::HeldW-1:0] group_q, group_d, group_eff;
  logic [rs14_pkg::PosW-1:0]  pos_q, pos_d, pos_eff;
  logic [rs14_pkg::CntW-1:0]  count_q, count_d, count_eff;
  logic [rs14_pkg::CntW-1:0]  tgt;
  logic [rs14_pkg::WordW-1:0] word;
  logic [rs14_pkg::CntW-1:0]  run [rs14_pkg::NumCand+1];
  logic                       accept, complete, closing;
  rs14_pkg::bundle_t          bundle;

  // a closing byte needs the result buffer free
  assign in_i.ready = (pos_q != rs14_pkg::LastPos) || !busy_i;
  assign accept     = in_i.valid & in_i.ready;

  // target saturates at the polynomial size
  assign tgt = (target_i > rs14_pkg::MaxCnt) ? rs14_pkg::MaxCnt : target_i;

  // new polynomial clears count and group ahead of the byte
  assign group_eff = in_i.new_poly ? '0 : group_q;
  assign pos_eff   = in_i.new_poly ? '0 : pos_q;
  assign count_eff = in_i.new_poly ? '0 : count_q;
  assign complete  = count_eff >= tgt;
  assign closing   = !complete && (pos_eff == rs14_pkg::LastPos);

  assign word = {in_i.rand_byte, group_eff};

  // candidate tests in order, count running through the group
  always_comb begin
    bundle = '0;
    run[0] = count_eff;
    for (int k = 0; k < rs14_pkg::NumCand; k++) begin
      bundle.coef[k] = word[k*rs14_pkg::CandW +: rs14_pkg::CandW];
      bundle.take[k] = (rs14_pkg::ModW'(bundle.coef[k]) < modulus_i) && (run[k] < tgt);
      bundle.idx[k]  = run[k][rs14_pkg::IdxW-1:0];
      bundle.last[k] = (run[k] + rs14_pkg::CntW'(1)) == tgt;
      run[k+1]       = run[k] + rs14_pkg::CntW'(bundle.take[k]);
    end
  end

  // next group state
  always_comb begin
    group_d = group_q;
    pos_d   = pos_q;
    count_d = count_q;
    if (accept) begin
      priority if (complete) begin
        group_d = group_eff;
        pos_d   = pos_eff;
        count_d = count_eff;
      end else if (closing) begin
        group_d = '0;
        pos_d   = '0;
        count_d = run[rs14_pkg::NumCand];
      end else begin
        count_d = count_eff;
        if (in_i.buffer_end) begin
          group_d = '0;
          pos_d   = '0;
        end else begin
          group_d = group_eff |
                    (rs14_pkg::HeldW'(in_i.rand_byte) << (rs14_pkg::ByteW * pos_eff));
          pos_d   = pos_eff + rs14_pkg::PosW'(1);
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      pos_q   <= '0;
      count_q <= '0;
    end else begin
      group_q <= group_d;
      pos_q   <= pos_d;
      count_q <= count_d;
    end
  end

  assign load_o   = accept & closing;
  assign bundle_o = bundle;

endmodule

/* sv/rs14_outq.sv */
module rs14_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rs14_pkg::bundle_t bundle_i,
  output logic              busy_o,
  rs14_out_if.source        out_o
);

  logic [rs14_pkg::NumCand-1:0] mask_q, mask_d;
  rs14_pkg::cand_t [rs14_pkg::NumCand-1:0] coef_q;
  rs14_pkg::idx_t  [rs14_pkg::NumCand-1:0] idx_q;
  logic [rs14_pkg::NumCand-1:0] last_q;
  logic                         ov_q, ov_d, advance;
  rs14_pkg::cand_t              coef_q_o, coef_d_o;
  rs14_pkg::idx_t               idx_q_o, idx_d_o;
  logic                         last_q_o, last_d_o;

  assign busy_o  = mask_q != '0;
  assign advance = !ov_q || out_o.ready;

  // pop the lowest pending slot into the output register
  always_comb begin
    mask_d   = mask_q;
    ov_d     = ov_q;
    coef_d_o = coef_q_o;
    idx_d_o  = idx_q_o;
    last_d_o = last_q_o;
    if (advance) begin
      ov_d = 1'b0;
      for (int k = rs14_pkg::NumCand - 1; k >= 0; k--) begin
        if (mask_q[k]) begin
          ov_d     = 1'b1;
          coef_d_o = coef_q[k];
          idx_d_o  = idx_q[k];
          last_d_o = last_q[k];
        end
      end
      mask_d = mask_q & (mask_q - rs14_pkg::NumCand'(1));
    end
    if (load_i) begin
      mask_d = bundle_i.take;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      mask_q <= mask_d;
      ov_q   <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      coef_q <= bundle_i.coef;
      idx_q  <= bundle_i.idx;
      last_q <= bundle_i.last;
    end
    coef_q_o <= coef_d_o;
    idx_q_o  <= idx_d_o;
    last_q_o <= last_d_o;
  end

  assign out_o.valid       = ov_q;
  assign out_o.coefficient = coef_q_o;
  assign out_o.coeff_index = idx_q_o;
  assign out_o.last_coeff  = last_q_o;

endmodule
